// ===== hw/rtl/wmvc_pkg.sv =====
// Package for the weighted majority vote combiner: register indexes,
// sequencer states and fixed-point constants. No dependencies.
`default_nettype none
package wmvc_pkg;
  localparam int VOTE_W = 16;
  localparam int WEIGHT_W = 32;
  localparam int RESULT_W = 32;
  localparam int MAX_MODELS = 4;
  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [31:0] HALF_Q24 = 32'h0080_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] NEG_ONE_Q16 = -32'sh0001_0000;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_RIGHT = 3'd1,
    REG_DUAL = 3'd2,
    REG_RATE = 3'd3,
    REG_COUNT = 3'd4,
    REG_INIT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_MAJORITY = 2'd0,
    MODE_ANY = 2'd1,
    MODE_ALL = 2'd2,
    MODE_WEIGHTED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FINISH,
    ST_UPD_START,
    ST_UPD_DIV,
    ST_OUT
  } state_t;

  // Divider control between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/wmvc_if.sv =====
// Valid/ready channel interface used for vote and result beats.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface wmvc_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wmvc_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit
// divisor, quotient truncated to 32 bits. Uses wmvc_pkg.
`default_nettype none
module wmvc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wmvc_pkg::div_req_t req,
  output wmvc_pkg::div_rsp_t     rsp
);
  import wmvc_pkg::*;

  logic [63:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  always_comb begin
    trial = {rem, quo[63]} - {33'd0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        // shift in one dividend bit, subtract when it fits
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo[31:0];
endmodule
`default_nettype wire

// ===== hw/rtl/weighted_majority_vote_combiner_core.sv =====
// Top level of the weighted majority vote combiner: APB registers, weight
// store, multiply-accumulate sequencer. Uses wmvc_pkg, wmvc_if, wmvc_div.
//
// channel | dir | payload
// in_ch   | in  | vote_left_0..3, vote_right_0..3 (16b signed Q4.12)
// out_ch  | out | combined_vote (32b Q16.16), positive_votes (4b)
// apb     | in  | register writes and reads, 32-bit data
//
// An item is accepted, multiplied and summed over L models (left votes, plus
// right votes when on) and finished; in weighted mode each weight is then
// updated by a divide (L or 2L divides, dual peak off or on) and the result is
// handed to the output register; the single 32x16 multiplier and divider pace it.
// Reset loads ONE_Q24 into initial_weight and all weights and clears the position count.
// A result held on out_ch stalls the next item at its handoff only, until taken.
`default_nettype none
module weighted_majority_vote_combiner_core #(
  parameter int MODELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  wmvc_if.sink             in_ch,
  wmvc_if.source           out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import wmvc_pkg::*;

  localparam int MW = $clog2(MODELS) + 1;
  localparam int IW = (MODELS > 1) ? $clog2(MODELS) : 1;

  // configuration
  logic [1:0]  combine_mode;
  logic        right_votes_present;
  logic        dual_peak;
  logic [23:0] combine_rate;
  logic [2:0]  model_count;
  logic [31:0] initial_weight;
  logic        wr_en;
  reg_idx_t    wr_idx;

  logic [31:0] weight_left [MODELS];
  logic [31:0] weight_right [MODELS];
  logic [31:0] position_count;

  logic signed [15:0] vl [MODELS];
  logic signed [15:0] vr [MODELS];

  state_t state, state_next;
  logic [MW-1:0] len;
  logic [MW-1:0] len_in;
  logic [MW-1:0] idx;
  logic          side;
  logic signed [55:0] acc;
  logic [3:0]  votec;
  logic [31:0] n;
  logic signed [31:0] q_res;
  logic [3:0]  votec_out;
  logic        sv_pos, sv_zero;
  logic        out_valid;
  logic signed [31:0] out_q;
  logic [3:0]  out_votec;

  logic [31:0] mul_w;
  logic signed [15:0] mul_v;
  logic signed [48:0] prod;
  logic [IW-1:0] ix;

  logic signed [57:0] total;
  logic signed [57:0] neg_total;
  logic signed [36:0] q_wide;
  logic signed [31:0] q_sat;

  div_req_t dreq;
  div_rsp_t drsp;
  logic [63:0] base;
  logic [31:0] w_cur;
  logic signed [15:0] v_cur;
  logic agree;

  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:  prdata = {30'd0, combine_mode};
      REG_RIGHT: prdata = {31'd0, right_votes_present};
      REG_DUAL:  prdata = {31'd0, dual_peak};
      REG_RATE:  prdata = {8'd0, combine_rate};
      REG_COUNT: prdata = {29'd0, model_count};
      REG_INIT:  prdata = initial_weight;
      default:   prdata = '0;
    endcase
  end

  assign ix = idx[IW-1:0];
  assign len_in = ({29'd0, model_count} > 32'(MODELS)) ? MW'(MODELS) : MW'(model_count);

  // shared multiplier, one product per cycle
  always_comb begin
    mul_w = side ? weight_right[ix] : weight_left[ix];
    mul_v = side ? vr[ix] : vl[ix];
    prod  = $signed({1'b0, mul_w}) * mul_v;
  end

  always_comb begin
    total = 58'(acc) + (58'(len) <<< 36) - ((58'(combine_rate) * 58'(len)) <<< 21);
    neg_total = -total;
    if (!total[57]) begin
      q_wide = 37'(total >>> 21);
    end else begin
      q_wide = -37'((neg_total + 58'h1F_FFFF) >>> 21);
    end
    if (q_wide > 37'sd2147483647) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (q_wide < -37'sd2147483648) begin
      q_sat = 32'sh8000_0000;
    end else begin
      q_sat = q_wide[31:0];
    end
  end

  always_comb begin
    w_cur = side ? weight_right[ix] : weight_left[ix];
    v_cur = side ? vr[ix] : vl[ix];
    base  = 64'(n - 32'd1) * 64'(w_cur);
    agree = (v_cur == 16'sd0) ? sv_zero
          : (v_cur > 16'sd0) ? (sv_pos && !sv_zero) : (!sv_pos && !sv_zero);
    dreq.start = (state == ST_UPD_START);
    dreq.divisor = n;
    if (agree) begin
      dreq.dividend = base + 64'(ONE_Q24);
    end else if (base < 64'(ONE_Q24)) begin
      dreq.dividend = 64'(HALF_Q24);
    end else begin
      dreq.dividend = base - 64'(ONE_Q24);
    end
  end

  wmvc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_ch.valid) state_next = (len_in == '0) ? ST_FINISH : ST_SUM;
      ST_SUM: begin
        if ((side || !right_votes_present) && idx == len - MW'(1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = (combine_mode == MODE_WEIGHTED && len != '0) ? ST_UPD_START : ST_OUT;
      end
      ST_UPD_START: state_next = ST_UPD_DIV;
      ST_UPD_DIV: begin
        if (drsp.done) begin
          if ((side || !dual_peak) && idx == len - MW'(1)) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_UPD_START;
          end
        end
      end
      ST_OUT:    if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = {out_q, out_votec};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the result beat until taken; refill from the handoff cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode        <= MODE_WEIGHTED;
      right_votes_present <= 1'b1;
      dual_peak           <= 1'b0;
      combine_rate        <= '0;
      model_count         <= 3'd4;
      initial_weight      <= ONE_Q24;
      position_count      <= '0;
      for (int m = 0; m < MODELS; m++) begin
        weight_left[m]  <= ONE_Q24;
        weight_right[m] <= ONE_Q24;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_idx)
          REG_MODE:  combine_mode <= pwdata[1:0];
          REG_RIGHT: right_votes_present <= pwdata[0];
          REG_DUAL:  dual_peak <= pwdata[0];
          REG_RATE:  combine_rate <= pwdata[23:0];
          REG_COUNT: model_count <= pwdata[2:0];
          REG_INIT: begin
            initial_weight <= pwdata;
            for (int m = 0; m < MODELS; m++) begin
              weight_left[m]  <= pwdata;
              weight_right[m] <= pwdata;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_IDLE && in_ch.valid && position_count != 32'hFFFF_FFFF) begin
        position_count <= position_count + 32'd1;
      end
      if (state == ST_UPD_DIV && drsp.done) begin
        if (side) begin
          weight_right[ix] <= drsp.quotient;
        end else begin
          weight_left[ix] <= drsp.quotient;
          if (!dual_peak) weight_right[ix] <= drsp.quotient;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          for (int m = 0; m < MODELS; m++) begin
            vl[m] <= in_ch.data[(2*MAX_MODELS-1-m)*VOTE_W +: VOTE_W];
            vr[m] <= in_ch.data[(MAX_MODELS-1-m)*VOTE_W +: VOTE_W];
          end
          len   <= len_in;
          n     <= (position_count == 32'hFFFF_FFFF) ? position_count
                   : position_count + 32'd1;
          acc   <= '0;
          votec <= '0;
          idx   <= '0;
          side  <= 1'b0;
        end
      end
      ST_SUM: begin
        acc <= acc + 56'(prod);
        if (mul_v > 16'sd0) votec <= votec + 4'd1;
        // advance: left then right of each model, left only when right votes are off
        if (side || !right_votes_present) begin
          side <= 1'b0;
          idx  <= idx + MW'(1);
        end else begin
          side <= 1'b1;
        end
      end
      ST_FINISH: begin
        votec_out <= votec;
        sv_pos  <= !total[57];
        sv_zero <= (total == '0);
        idx  <= '0;
        side <= 1'b0;
        unique case (combine_mode)
          MODE_ANY: q_res <= (votec != 4'd0) ? ONE_Q16 : NEG_ONE_Q16;
          MODE_ALL: q_res <= (votec == 4'(len)) ? ONE_Q16 : NEG_ONE_Q16;
          default:  q_res <= q_sat;
        endcase
      end
      ST_UPD_DIV: begin
        if (drsp.done) begin
          if (side || !dual_peak) begin
            side <= 1'b0;
            idx  <= idx + MW'(1);
          end else begin
            side <= 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ch.ready) begin
          out_q     <= q_res;
          out_votec <= votec_out;
        end
      end
      default: ;
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("second beat taken in flight");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped before taken");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy) else $error("divider restarted while busy");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for weighted_majority_vote_combiner_core: drives vote
// beats and APB register writes, predicts every result beat and compares it.
// Depends on wmvc_pkg, wmvc_if and the core RTL.
module tb;
  import wmvc_pkg::*;

  localparam int LIMIT_CYCLES = 6000000;
  localparam logic [2:0] REG_SPARE = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [15:0] vote_left_0;
    logic signed [15:0] vote_left_1;
    logic signed [15:0] vote_left_2;
    logic signed [15:0] vote_left_3;
    logic signed [15:0] vote_right_0;
    logic signed [15:0] vote_right_1;
    logic signed [15:0] vote_right_2;
    logic signed [15:0] vote_right_3;
  } vote_beat_t;

  typedef struct packed {
    logic signed [31:0] combined_vote;
    logic [3:0]         positive_votes;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wmvc_if #(.PAYLOAD_T(vote_beat_t)) in_ch ();
  wmvc_if #(.PAYLOAD_T(result_beat_t)) out_ch ();

  weighted_majority_vote_combiner_core #(.MODELS(MAX_MODELS)) i_dut (
    .clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow of the block's configuration and weight state
  mode_t       cur_mode;
  logic        cur_right, cur_dual;
  logic [23:0] cur_rate;
  logic [2:0]  cur_count;
  logic [31:0] cur_init;
  logic [31:0] w_left[MAX_MODELS], w_right[MAX_MODELS];
  logic [31:0] pos_count;

  vote_beat_t   vote_queue[$];
  result_beat_t result_queue[$];
  int           errors = 0;
  int           cycles = 0;
  int           snd_idle_pct = 16, rcv_idle_pct = 50;
  logic         in_fire = 1'b0;
  logic         hold_go = 1'b0, hold_seen = 1'b0;
  int           hold_cnt = 0;
  logic         stim_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int sgn(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic logic [31:0] next_weight(logic [31:0] w, bit agree, logic [31:0] n);
    logic [63:0] base, t;
    base = 64'(n - 32'd1) * 64'(w);
    if (agree) t = base + 64'(ONE_Q24);
    else if (base < 64'(ONE_Q24)) t = 64'(HALF_Q24);
    else t = base - 64'(ONE_Q24);
    return 32'(t / 64'(n));
  endfunction

  function automatic result_beat_t combine_votes(vote_beat_t b);
    longint vl[MAX_MODELS], vr[MAX_MODELS];
    longint sum, total, q;
    int len, votec, sv;
    result_beat_t r;
    vl = '{longint'(b.vote_left_0), longint'(b.vote_left_1),
           longint'(b.vote_left_2), longint'(b.vote_left_3)};
    vr = '{longint'(b.vote_right_0), longint'(b.vote_right_1),
           longint'(b.vote_right_2), longint'(b.vote_right_3)};
    len = (cur_count > MAX_MODELS) ? MAX_MODELS : int'(cur_count);
    sum = 0;
    votec = 0;
    if (pos_count != 32'hFFFF_FFFF) pos_count = pos_count + 1;
    for (int m = 0; m < len; m++) begin
      sum += longint'({32'b0, w_left[m]}) * vl[m];
      if (vl[m] > 0) votec++;
      if (cur_right) begin
        sum += longint'({32'b0, w_right[m]}) * vr[m];
        if (vr[m] > 0) votec++;
      end
    end
    total = sum + (longint'(len) <<< 36) - ((longint'(cur_rate) * 2 * longint'(len)) <<< 20);
    q = total >>> 21;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    case (cur_mode)
      MODE_ANY: q = (votec > 0) ? longint'(ONE_Q16) : longint'(NEG_ONE_Q16);
      MODE_ALL: q = (votec == len) ? longint'(ONE_Q16) : longint'(NEG_ONE_Q16);
      MODE_WEIGHTED: begin
        sv = sgn(total);
        for (int m = 0; m < len; m++) begin
          w_left[m] = next_weight(w_left[m], sgn(vl[m]) == sv, pos_count);
          if (cur_dual) w_right[m] = next_weight(w_right[m], sgn(vr[m]) == sv, pos_count);
          else w_right[m] = w_left[m];
        end
      end
      default: ;
    endcase
    r.combined_vote = 32'(q);
    r.positive_votes = 4'(votec);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // input driver: hold a beat until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_fire) begin
      if (vote_queue.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= vote_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rst && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // predict on acceptance, check on delivery
  always @(posedge clk) begin
    result_beat_t want;
    cycles++;
    in_fire <= in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) result_queue.push_back(combine_votes(in_ch.data));
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (result_queue.size() == 0) begin
        report("unexpected result beat", out_ch.data.combined_vote, 0);
      end else begin
        want = result_queue.pop_front();
        if (out_ch.data.combined_vote !== want.combined_vote)
          report("combined_vote", out_ch.data.combined_vote, want.combined_vote);
        if (out_ch.data.positive_votes !== want.positive_votes)
          report("positive_votes", out_ch.data.positive_votes, want.positive_votes);
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] full_weight_load(logic [31:0] v);
    for (int m = 0; m < MAX_MODELS; m++) begin
      w_left[m] = v;
      w_right[m] = v;
    end
    return v;
  endfunction

  task automatic drain();
    while (!(vote_queue.size() == 0 && !in_ch.valid && result_queue.size() == 0))
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE: cur_mode = mode_t'(v[1:0]);
      REG_RIGHT: cur_right = v[0];
      REG_DUAL: cur_dual = v[0];
      REG_RATE: cur_rate = v[23:0];
      REG_COUNT: cur_count = v[2:0];
      REG_INIT: cur_init = full_weight_load(v);
      default: ;
    endcase
  endtask

  task automatic set_all(mode_t md, bit rv, bit dp, logic [23:0] rate, logic [2:0] cnt,
                         logic [31:0] iw);
    drain();
    reg_write(REG_MODE, 32'(md));
    reg_write(REG_RIGHT, 32'(rv));
    reg_write(REG_DUAL, 32'(dp));
    reg_write(REG_RATE, 32'(rate));
    reg_write(REG_COUNT, 32'(cnt));
    reg_write(REG_INIT, iw);
  endtask

  function automatic logic [15:0] pick_vote();
    case ($urandom_range(5))
      0: return 16'sd0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vote_beat_t random_beat();
    logic [15:0] v[8];
    for (int k = 0; k < 8; k++) v[k] = pick_vote();
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  function automatic vote_beat_t flat_beat(logic [15:0] v);
    return {8{v}};
  endfunction

  initial begin
    cur_mode = MODE_WEIGHTED;
    cur_right = 1'b1;
    cur_dual = 1'b0;
    cur_rate = '0;
    cur_count = 3'd4;
    cur_init = full_weight_load(ONE_Q24);
    pos_count = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: zero, extremes, mixed signs
    vote_queue.push_back(flat_beat(16'h0000));
    vote_queue.push_back(flat_beat(16'h7FFF));
    vote_queue.push_back(flat_beat(16'h8000));
    vote_queue.push_back({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                          16'h8000, 16'h7FFF, 16'h0000, 16'h1000});
    vote_queue.push_back(flat_beat(16'hFFFF));
    // each mode, right votes on and off, count out of range and zero
    set_all(MODE_MAJORITY, 1'b0, 1'b0, 24'hFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    vote_queue.push_back(flat_beat(16'h7FFF));
    vote_queue.push_back(flat_beat(16'h8000));
    set_all(MODE_ANY, 1'b1, 1'b1, 24'h00_0000, 3'd0, 32'h0000_0000);
    vote_queue.push_back(flat_beat(16'h7FFF));
    vote_queue.push_back(flat_beat(16'h0001));
    set_all(MODE_ALL, 1'b1, 1'b0, 24'h01_0000, 3'd1, ONE_Q24);
    vote_queue.push_back({16'h0001, 48'h0, 16'h8000, 48'h0});
    vote_queue.push_back({16'h8000, 48'h0, 16'h0001, 48'h0});
    vote_queue.push_back(flat_beat(16'h0001));
    set_all(MODE_WEIGHTED, 1'b1, 1'b1, 24'h00_8000, 3'd5, 32'hFFFF_FFFF);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h0);
    vote_queue.push_back(flat_beat(16'h8000));
    vote_queue.push_back(random_beat());
    vote_queue.push_back(flat_beat(16'h0000));
    vote_queue.push_back(flat_beat(16'h7FFF));

    for (int p = 0; p < 9; p++) begin
      logic [23:0] rate;
      logic [31:0] iw;
      drain();
      if (p < 3) begin snd_idle_pct = 16; rcv_idle_pct = 50; end
      else if (p < 6) begin snd_idle_pct = 50; rcv_idle_pct = 16; end
      else begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      rate = (p == 4) ? 24'hFF_FFFF : 24'($urandom_range(131072));
      iw = (p == 2) ? 32'hFFFF_FFFF : ((p == 7) ? 32'h0 : 32'($urandom));
      if (p % 2 == 0) iw = ONE_Q24;
      set_all(mode_t'(p % 4 == 1 ? MODE_WEIGHTED : p % 4), 1'($urandom), 1'($urandom), rate,
              3'($urandom_range(1, 4)), iw);
      // pile up beats behind a stalled receiver
      if (p == 6) hold_go = !hold_go;
      for (int k = 0; k < 154; k++) vote_queue.push_back(random_beat());
    end

    drain();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
